// ===== sv/itoar_pkg.sv =====
// itoar_pkg: shared types, constants and helpers for the integer to ascii converter
`timescale 1ns / 1ps

package itoar_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_DIGITS  = 22;
   localparam int DIGIT_W     = 4;
   localparam int CHAR_W      = 7;
   localparam int COUNT_W     = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 7'd45;

   typedef enum logic [1:0] {
      CMD_SDEC = 2'd0,
      CMD_UDEC = 2'd1,
      CMD_OCT  = 2'd2,
      CMD_HEX  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic clear;
      logic conv;
      logic shift;
   } chain_ctrl_type;

   function automatic logic [CHAR_W-1:0] ascii_of_digit(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      if (d < DIGIT_W'(10)) begin
         return ext + CHAR_ZERO;
      end else begin
         return ext + CHAR_LETTER;
      end
   endfunction

endpackage

// ===== sv/itoar_digit_chain.sv =====
// itoar_digit_chain: shift register of digit cells for bit-serial radix conversion
`timescale 1ns / 1ps

module itoar_digit_chain
   import itoar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  chain_ctrl_type       ctrl,
   input  cmd_type              cmd,
   input  logic                 bit_in,
   output logic [DIGIT_W-1:0]   top_digit,
   output logic                 overflow
);

   logic [DIGIT_W-1:0] digits_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0] digits_in [MAX_DIGITS];
   logic [DIGIT_W-1:0] adj       [MAX_DIGITS];
   logic [DIGIT_W-1:0] stepped   [MAX_DIGITS];
   logic               cin       [MAX_DIGITS];
   logic               cout      [MAX_DIGITS];
   logic               overflow_ff;
   logic               overflow_in;

   // per-cell doubling step, carry depends only on the cell itself
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[i] = (digits_ff[i] >= DIGIT_W'(5)) ? digits_ff[i] + DIGIT_W'(3) : digits_ff[i];
         cin[i] = (i == 0) ? bit_in : cout[(i == 0) ? 0 : i - 1];
         case (cmd)
            CMD_SDEC, CMD_UDEC: begin
               stepped[i] = {adj[i][2:0], cin[i]};
               cout[i]    = adj[i][3];
            end
            CMD_OCT: begin
               stepped[i] = {1'b0, digits_ff[i][1:0], cin[i]};
               cout[i]    = digits_ff[i][2];
            end
            default: begin
               stepped[i] = {digits_ff[i][2:0], cin[i]};
               cout[i]    = digits_ff[i][3];
            end
         endcase
      end
   end

   always_comb begin
      overflow_in = overflow_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end
      if (ctrl.clear) begin
         overflow_in = 1'b0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_in[i] = '0;
         end
      end else if (ctrl.conv) begin
         overflow_in = overflow_ff | cout[MAX_DIGITS-1];
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_in[i] = stepped[i];
         end
      end else if (ctrl.shift) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_in[i] = (i == 0) ? '0 : digits_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits_ff[i] <= digits_in[i];
      end
      if (reset) begin
         overflow_ff <= 1'b0;
      end else begin
         overflow_ff <= overflow_in;
      end
   end

   assign top_digit = digits_ff[MAX_DIGITS-1];
   assign overflow  = overflow_ff;

endmodule

// ===== sv/integer_to_ascii_radix_top.sv =====
// integer_to_ascii_radix_top: integer to ascii converter, decimal, octal or hex
`timescale 1ns / 1ps

// Takes a 64-bit value and a format (signed decimal, unsigned decimal, octal,
// upper-case hex) and returns its ASCII characters most significant first, one
// response per character, a leading minus for negative signed decimal, zero as
// a single "0". The final character has rsp_last_char set and rsp_char_count
// holds the total. One request is converted at a time: the value is shifted
// bit by bit into a chain of 22 digit cells, then the chain is shifted out
// one digit position per cycle, skipping leading zeros; digit output waits
// while the response is stalled.

module integer_to_ascii_radix_top
   import itoar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  logic [63:0]          req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHAR_W-1:0]    rsp_char_code,
   output logic                 rsp_last_char,
   output logic [COUNT_W-1:0]   rsp_char_count
);

   localparam int BIT_W = $clog2(VALUE_WIDTH);
   localparam int REM_W = $clog2(MAX_DIGITS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_SKIP,
      ST_DIGIT
   } state_type;

   state_type               state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic [BIT_W-1:0]        bitcnt_ff, bitcnt_in;
   logic [REM_W-1:0]        remain_ff, remain_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   cmd_type                 cmd_ff, cmd_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   chain_ctrl_type          chain_ctrl;
   logic [DIGIT_W-1:0]      top_digit;
   logic                    overflow;
   logic                    out_free;
   logic                    skip_zero;
   logic [VALUE_WIDTH-1:0]  load_value;
   logic                    load_neg;

   itoar_digit_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .cmd       (cmd_ff),
      .bit_in    (value_ff[VALUE_WIDTH-1]),
      .top_digit (top_digit),
      .overflow  (overflow)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign load_value = req_value[VALUE_WIDTH-1:0];
   assign load_neg   = (cmd_type'(req_cmd) == CMD_SDEC) && load_value[VALUE_WIDTH-1];
   assign skip_zero  = (remain_ff > REM_W'(1)) && (top_digit == '0) && !overflow;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      bitcnt_in    = bitcnt_ff;
      remain_in    = remain_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      chain_ctrl   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in           = cmd_type'(req_cmd);
               neg_in           = load_neg;
               value_in         = load_neg ? (~load_value + VALUE_WIDTH'(1)) : load_value;
               bitcnt_in        = '0;
               count_in         = '0;
               chain_ctrl.clear = 1'b1;
               state_in         = ST_CONV;
            end
         end
         ST_CONV: begin
            chain_ctrl.conv = 1'b1;
            value_in        = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            bitcnt_in       = bitcnt_ff + BIT_W'(1);
            if (bitcnt_ff == BIT_W'(VALUE_WIDTH - 1)) begin
               remain_in = REM_W'(MAX_DIGITS);
               state_in  = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               rsp_count_in = COUNT_W'(1);
               count_in     = COUNT_W'(1);
               state_in     = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (skip_zero) begin
               chain_ctrl.shift = 1'b1;
               remain_in        = remain_ff - REM_W'(1);
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               chain_ctrl.shift = 1'b1;
               rsp_valid_in     = 1'b1;
               rsp_char_in      = ascii_of_digit(top_digit);
               rsp_last_in      = (remain_ff == REM_W'(1));
               rsp_count_in     = count_ff + COUNT_W'(1);
               count_in         = count_ff + COUNT_W'(1);
               remain_in        = remain_ff - REM_W'(1);
               if (remain_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      bitcnt_ff    <= bitcnt_in;
      remain_ff    <= remain_in;
      count_ff     <= count_in;
      cmd_ff       <= cmd_in;
      neg_ff       <= neg_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_code  = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;
   assign rsp_char_count = rsp_count_ff;

`ifndef SYNTH
   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CONV)
      else $error("accepted request did not start conversion");

   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff && cmd_ff == CMD_SDEC)
      else $error("minus sign phase without negative signed value");

   a_minus_is_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CHAR_MINUS |-> rsp_char_count == COUNT_W'(1) && !rsp_last_char)
      else $error("minus sign not leading or flagged last");

   a_rsp_held_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code)
         && $stable(rsp_last_char) && $stable(rsp_char_count))
      else $error("response changed while stalled");
`endif

endmodule

// ===== verif/integer_to_ascii_radix_top_tb.sv =====
// integer_to_ascii_radix_top_tb: self-checking bench for the integer to ascii radix converter
`timescale 1ns / 1ps

module integer_to_ascii_radix_top_tb;
   import itoar_pkg::*;

   typedef struct packed {
      cmd_type     fmt;
      logic [63:0] value;
   } number_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]  code;
      logic               is_last;
      logic [COUNT_W-1:0] count;
   } ascii_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_cmd = 2'd0;
   logic [63:0]        req_value = 64'd0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CHAR_W-1:0]  rsp_char_code;
   logic               rsp_last_char;
   logic [COUNT_W-1:0] rsp_char_count;

   number_req_type numbers_to_send[$];
   ascii_char_type expected_chars[$];

   int mismatch_count = 0;
   int chars_checked  = 0;
   int negatives_seen = 0;
   int fmt_seen[4]    = '{0, 0, 0, 0};
   int burst_left     = 0;
   int gap_left       = 0;
   int stall_mode     = 0;
   int stall_left     = 0;
   int stall_phase    = 0;

   integer_to_ascii_radix_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_code  (rsp_char_code),
      .rsp_last_char  (rsp_last_char),
      .rsp_char_count (rsp_char_count)
   );

   always #5 clock = ~clock;

   // expected characters of one number, most significant first
   function automatic void render_number(input cmd_type fmt, input logic [63:0] value);
      logic [63:0]        magnitude;
      logic [63:0]        radix;
      logic               negative;
      logic [3:0]         digits[MAX_DIGITS];
      int                 ndigits;
      int                 emitted;
      ascii_char_type     ch;
      negative  = (fmt == CMD_SDEC) && value[63];
      magnitude = negative ? (~value + 64'd1) : value;
      case (fmt)
         CMD_OCT: radix = 64'd8;
         CMD_HEX: radix = 64'd16;
         default: radix = 64'd10;
      endcase
      ndigits = 0;
      do begin
         digits[ndigits] = 4'(magnitude % radix);
         magnitude = magnitude / radix;
         ndigits++;
      end while (magnitude != 64'd0 && ndigits < MAX_DIGITS);
      emitted = 0;
      if (negative) begin
         emitted++;
         ch.code    = CHAR_MINUS;
         ch.is_last = 1'b0;
         ch.count   = COUNT_W'(emitted);
         expected_chars.push_back(ch);
         negatives_seen++;
      end
      for (int k = ndigits - 1; k >= 0; k--) begin
         emitted++;
         ch.code    = {3'b000, digits[k]} + ((digits[k] < 4'd10) ? CHAR_ZERO : CHAR_LETTER);
         ch.is_last = (k == 0);
         ch.count   = COUNT_W'(emitted);
         expected_chars.push_back(ch);
      end
   endfunction

   task automatic add_number(input cmd_type fmt, input logic [63:0] value);
      number_req_type item;
      item.fmt   = fmt;
      item.value = value;
      numbers_to_send.push_back(item);
   endtask

   // request driver: bursts of back-to-back requests separated by random gaps
   always @(posedge clock) begin
      number_req_type item;
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd   <= 2'd0;
         req_value <= 64'd0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (numbers_to_send.size() > 0) begin
            item = numbers_to_send.pop_front();
            req_valid <= 1'b1;
            req_cmd   <= item.fmt;
            req_value <= item.value;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 8);
               case ($urandom_range(0, 3))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 120);
                  default: gap_left = $urandom_range(1, 20);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure: random pattern, re-chosen when its stall_left count runs out
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
         end else begin
            stall_left--;
         end
         stall_phase++;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (stall_phase % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // monitor: predict on accepted requests, check accepted characters
   always @(posedge clock) begin
      ascii_char_type got;
      ascii_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            render_number(cmd_type'(req_cmd), req_value);
            fmt_seen[req_cmd]++;
         end
         if (rsp_valid && rsp_ready) begin
            got.code    = rsp_char_code;
            got.is_last = rsp_last_char;
            got.count   = rsp_char_count;
            chars_checked++;
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected char code=%0d last=%0d count=%0d",
                           $realtime, got.code, got.is_last, got.count);
            end else begin
               want = expected_chars.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: char mismatch exp code=%0d last=%0d count=%0d,",
                               " got code=%0d last=%0d count=%0d"},
                              $realtime, want.code, want.is_last, want.count,
                              got.code, got.is_last, got.count);
               end
            end
         end
      end
   end

   initial begin
      logic [63:0] value;
      int          width;
      add_number(CMD_SDEC, 64'd0);
      add_number(CMD_SDEC, 64'd1);
      add_number(CMD_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
      add_number(CMD_SDEC, 64'h8000_0000_0000_0000);
      add_number(CMD_SDEC, 64'h7FFF_FFFF_FFFF_FFFF);
      add_number(CMD_SDEC, ~64'd1234567890 + 64'd1);
      add_number(CMD_SDEC, 64'd10);
      add_number(CMD_UDEC, 64'd0);
      add_number(CMD_UDEC, 64'hFFFF_FFFF_FFFF_FFFF);
      add_number(CMD_UDEC, 64'd9);
      add_number(CMD_UDEC, 64'h8000_0000_0000_0000);
      add_number(CMD_OCT, 64'd0);
      add_number(CMD_OCT, 64'hFFFF_FFFF_FFFF_FFFF);
      add_number(CMD_OCT, 64'd7);
      add_number(CMD_OCT, 64'd8);
      add_number(CMD_OCT, 64'o1234567);
      add_number(CMD_HEX, 64'd0);
      add_number(CMD_HEX, 64'hFFFF_FFFF_FFFF_FFFF);
      add_number(CMD_HEX, 64'hFEDC_BA98_7654_3210);
      add_number(CMD_HEX, 64'd15);
      add_number(CMD_HEX, 64'd16);
      add_number(CMD_HEX, 64'hA);
      for (int i = 0; i < 108; i++) begin
         width = $urandom_range(1, 63);
         case ($urandom_range(0, 5))
            0, 1: value = {$urandom, $urandom};
            2: value = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
            3: value = 64'($urandom_range(0, 30));
            4: value = ~({$urandom, $urandom} & ((64'd1 << width) - 64'd1)) + 64'd1;
            default: value = ($urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                                   : 64'hFFFF_FFFF_FFFF_FFFF)
                             ^ 64'($urandom_range(0, 255));
         endcase
         add_number(cmd_type'($urandom_range(0, 3)), value);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (numbers_to_send.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display({"converted %0d numbers: %0d signed dec (%0d negative),",
                " %0d unsigned dec, %0d octal, %0d hex"},
               fmt_seen[0] + fmt_seen[1] + fmt_seen[2] + fmt_seen[3], fmt_seen[0],
               negatives_seen, fmt_seen[1], fmt_seen[2], fmt_seen[3]);
      $display("checked %0d characters, %0d mismatches", chars_checked, mismatch_count);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("timeout with %0d characters outstanding", expected_chars.size());
      $display("FAILURE");
      $finish;
   end

endmodule
